@@ rtl/msrt_pkg.sv @@
// Package for the memory region sorter: capacity, record and control types.
// No dependencies; every other file of the block imports it.
`default_nettype none

package msrt_pkg;

  // Number of cells in the insertion chain (records held per run).
  localparam int MaxRecords = 32;

  localparam int AddrWidth = 64;
  localparam int SizeWidth = 64;
  localparam int TypeWidth = 8;

  typedef struct packed {
    logic                 valid;
    logic [AddrWidth-1:0] addr;
    logic [SizeWidth-1:0] size;
    logic [TypeWidth-1:0] rtype;
  } rec_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;  // place the new record in sorted position
    logic shift;   // move every record one cell toward the head
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

endpackage

`default_nettype wire

@@ rtl/msrt_if.sv @@
// Valid/ready channel interfaces of the memory region sorter.
// Depends on msrt_pkg for the field widths.
`default_nettype none

interface msrt_in_if import msrt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [AddrWidth-1:0] region_addr;
  logic [SizeWidth-1:0] region_size;
  logic [TypeWidth-1:0] region_type;
  logic                 last_record;

  modport source (output valid, region_addr, region_size, region_type, last_record,
                  input ready);
  modport sink   (input valid, region_addr, region_size, region_type, last_record,
                  output ready);
endinterface

interface msrt_out_if import msrt_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [AddrWidth-1:0] sorted_addr;
  logic [SizeWidth-1:0] sorted_size;
  logic [TypeWidth-1:0] sorted_type;
  logic                 final_result;
  logic                 overflowed;

  modport source (output valid, sorted_addr, sorted_size, sorted_type, final_result,
                  overflowed, input ready);
  modport sink   (input valid, sorted_addr, sorted_size, sorted_type, final_result,
                  overflowed, output ready);
endinterface

`default_nettype wire

@@ rtl/msrt_cell.sv @@
// One cell of the insertion chain: holds a single record.
// Depends on msrt_pkg.
`default_nettype none

module msrt_cell import msrt_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       new_i,
  input  rec_t       left_i,
  input  wire        left_gt_i,
  input  rec_t       right_i,
  output rec_t       rec_o,
  output logic       gt_o
);

  rec_t                 rec_q, rec_d;
  logic                 valid_q;
  logic [AddrWidth-1:0] addr_q;
  logic [SizeWidth-1:0] size_q;
  logic [TypeWidth-1:0] rtype_q;

  assign rec_q = {valid_q, addr_q, size_q, rtype_q};

  // An empty cell acts as an infinite key; strict compare keeps equal keys stable.
  assign gt_o  = !rec_q.valid || (rec_q.addr > new_i.addr);
  assign rec_o = rec_q;

  always_comb begin
    rec_d = rec_q;
    if (ctrl_i.shift) begin
      rec_d = right_i;
    end else if (ctrl_i.insert) begin
      if (left_gt_i) begin
        rec_d = left_i;
      end else if (gt_o) begin
        rec_d = new_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= rec_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= rec_d.addr;
    size_q  <= rec_d.size;
    rtype_q <= rec_d.rtype;
  end

endmodule

`default_nettype wire

@@ rtl/msrt_chain.sv @@
// Row of MaxRecords insertion cells, head at index 0.
// Depends on msrt_pkg and msrt_cell.
`default_nettype none

module msrt_chain import msrt_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  rec_t       new_i,
  output rec_t       recs_o [MaxRecords]
);

  rec_t                  recs     [MaxRecords];
  rec_t                  left_rec [MaxRecords];
  rec_t                  right_rec[MaxRecords];
  logic [MaxRecords-1:0] gt;
  logic [MaxRecords-1:0] left_gt;

  for (genvar i = 0; i < MaxRecords; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign left_rec[i] = '0;
      assign left_gt[i]  = 1'b0;
    end else begin : g_body
      assign left_rec[i] = recs[i-1];
      assign left_gt[i]  = gt[i-1];
    end

    if (i == MaxRecords - 1) begin : g_tail
      assign right_rec[i] = '0;
    end else begin : g_inner
      assign right_rec[i] = recs[i+1];
    end

    msrt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl_i),
      .new_i     (new_i),
      .left_i    (left_rec[i]),
      .left_gt_i (left_gt[i]),
      .right_i   (right_rec[i]),
      .rec_o     (recs[i]),
      .gt_o      (gt[i])
    );

    assign recs_o[i] = recs[i];
  end

endmodule

`default_nettype wire

@@ rtl/memory_region_sorter.sv @@
// Memory region sorter: top level with load/drain control around the cell chain.
// Depends on msrt_pkg, msrt_if, msrt_cell and msrt_chain.
//
// Usage:
//   rec_i carries memory-region records (address, size, type, last flag).
//   A transaction is accepted when valid and ready are both high. While loading,
//   ready is high and one record is taken every cycle; each record drops straight
//   into its sorted place in a chain of MaxRecords cells (one 64-bit compare per
//   cell against the broadcast record, equal addresses keep arrival order).
//   The record flagged last ends the run. In the cycle after it is accepted, srt_o
//   presents the smallest record from the head cell; each output transaction
//   shifts the whole chain one cell toward the head. final_result marks the
//   last record of the run, overflowed marks every record of a run in which
//   records beyond MaxRecords were dropped (the last record too still ends the
//   run when dropped). rec_i.ready stays low for the whole drain.
//   When the receiver stalls, the head cell simply holds and nothing moves.
//   Reset clears every cell's valid bit, the drop flag and the state: the block
//   comes up empty and ready to load.
`default_nettype none

module memory_region_sorter import msrt_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  msrt_in_if.sink     rec_i,
  msrt_out_if.source  srt_o
);

  state_e     state_q, state_d;
  logic       drop_q, drop_d;
  cell_ctrl_t ctrl;
  rec_t       new_rec;
  rec_t       recs [MaxRecords];
  logic       in_acc, out_acc, full, is_final;

  // Chain is full once the tail cell holds a record.
  assign full     = recs[MaxRecords-1].valid;
  // Head record is the last one when nothing sits behind it.
  assign is_final = !recs[1].valid;

  assign rec_i.ready = (state_q == ST_LOAD);
  assign in_acc      = rec_i.valid && rec_i.ready;

  assign srt_o.valid = (state_q == ST_DRAIN) && recs[0].valid;
  assign out_acc     = srt_o.valid && srt_o.ready;

  assign new_rec.valid = 1'b1;
  assign new_rec.addr  = rec_i.region_addr;
  assign new_rec.size  = rec_i.region_size;
  assign new_rec.rtype = rec_i.region_type;

  // Insert when there is room, drop otherwise; shift on every output transaction.
  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = out_acc;

  msrt_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .new_i  (new_rec),
    .recs_o (recs)
  );

  always_comb begin
    state_d = state_q;
    drop_d  = drop_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            drop_d = 1'b1;
          end
          if (rec_i.last_record) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // Return to empty after the final transaction of the run.
        if (out_acc && is_final) begin
          state_d = ST_LOAD;
          drop_d  = 1'b0;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      drop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      drop_q  <= drop_d;
    end
  end

  assign srt_o.sorted_addr  = recs[0].addr;
  assign srt_o.sorted_size  = recs[0].size;
  assign srt_o.sorted_type  = recs[0].rtype;
  assign srt_o.final_result = is_final;
  assign srt_o.overflowed   = drop_q;

endmodule

`default_nettype wire

@@ rtl/msrt_checker.sv @@
// Port-level checker for the memory region sorter, bound to the top level.
// Depends on msrt_pkg and on the top level's interface ports.
`default_nettype none

module msrt_checker import msrt_pkg::*; (
  input wire                 clk_i,
  input wire                 rst_ni,
  input wire                 in_valid_i,
  input wire                 in_ready_i,
  input wire                 in_last_i,
  input wire                 out_valid_i,
  input wire                 out_ready_i,
  input wire [AddrWidth-1:0] out_addr_i,
  input wire                 out_final_i,
  input wire                 out_ovf_i
);

  wire in_acc  = in_valid_i && in_ready_i;
  wire out_acc = out_valid_i && out_ready_i;

  // Loading and draining never overlap.
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while output valid");

  // End of run starts the drain on the next cycle.
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_last_i |=> out_valid_i)
    else $error("no output after last record");

  // Addresses leave in ascending order and the drop flag holds across a run.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !out_final_i |=> out_valid_i && out_addr_i >= $past(out_addr_i)
                                && out_ovf_i == $past(out_ovf_i))
    else $error("output order or overflow flag broken");

  // Final transaction hands control back to loading.
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && out_final_i |=> !out_valid_i && in_ready_i)
    else $error("block not ready after final record");

  // Stalled output holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_addr_i))
    else $error("stalled output changed");

endmodule

bind memory_region_sorter msrt_checker u_msrt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (rec_i.valid),
  .in_ready_i  (rec_i.ready),
  .in_last_i   (rec_i.last_record),
  .out_valid_i (srt_o.valid),
  .out_ready_i (srt_o.ready),
  .out_addr_i  (srt_o.sorted_addr),
  .out_final_i (srt_o.final_result),
  .out_ovf_i   (srt_o.overflowed)
);

`default_nettype wire
